@@ hdl/lsl_pkg.sv @@
package lsl_pkg;

    localparam int EXP_TABLE_DEPTH_DEF = 256;

    localparam int CODE_W  = 8;
    localparam int CNT_W   = 12;
    localparam int D_W     = CNT_W + 1;
    localparam int R_W     = 19;
    localparam int FRAC_W  = 16;
    localparam int NUM_W   = CNT_W + FRAC_W;
    localparam int CMP_W   = CNT_W + R_W;
    localparam int BIG_W   = CNT_W + 3;
    localparam int R2_W    = 22;
    localparam int E_W     = 17;
    localparam int DK_W    = 21;
    localparam int LUX_W   = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int CAL_F_W    = 16;
    localparam int CAL_O_W    = 21;

    localparam logic [6:0] CODE_OVERFLOW = 7'h7f;
    localparam int EXP_K_MILLI = 181;
    localparam logic [7:0] GAIN_STD = 8'd39;
    localparam logic [7:0] GAIN_EXT = 8'd195;
    localparam int LUX_MAX = 20000000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXT_RANGE  = 2'd0,
        CFG_CAL_FACTOR = 2'd1,
        CFG_CAL_OFFSET = 2'd2
    } cfg_index_t;

    typedef struct packed {
        status_t                 status;
        logic [CNT_W-1:0]        c1;
        logic signed [D_W-1:0]   d;
        logic [CNT_W-1:0]        ad;
    } diff_t;

    typedef struct packed {
        status_t                 status;
        logic signed [D_W-1:0]   d;
        logic [CNT_W-1:0]        ad;
        logic                    big;
        logic [NUM_W-1:0]        rem;
        logic [R_W-1:0]          q;
    } div_stage_t;

    typedef struct packed {
        status_t                 status;
        logic signed [D_W-1:0]   d;
        logic                    big;
        logic [R_W-1:0]          r;
    } ratio_t;

    typedef struct packed {
        status_t                 status;
        logic signed [DK_W-1:0]  dk;
        logic [E_W-1:0]          e;
    } expo_t;

    function automatic logic [CNT_W-1:0] count_of(input logic [6:0] code);
        logic [CNT_W-1:0] base;
        logic [2:0]       chord;
        chord = code[6:4];
        case (chord)
            3'd0:    base = 12'd0;
            3'd1:    base = 12'd16;
            3'd2:    base = 12'd49;
            3'd3:    base = 12'd115;
            3'd4:    base = 12'd247;
            3'd5:    base = 12'd511;
            3'd6:    base = 12'd1039;
            3'd7:    base = 12'd2095;
            default: base = 12'd0;
        endcase
        return base + (CNT_W'(code[3:0]) << chord);
    endfunction

    // exp(-y/2^32) in Q1.16: Taylor series on y/16, then four squarings
    function automatic logic [E_W-1:0] exp_from_y(input logic [63:0] y);
        logic [63:0]  z;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [63:0]  t;
        logic [63:0]  x;
        logic [127:0] prod;
        logic         done;
        z    = y >> 4;
        pos  = 64'd1 << 32;
        neg  = 64'd0;
        t    = 64'd1 << 32;
        done = 1'b0;
        for (int k = 1; k <= 40; k++)
        begin
            if (!done)
            begin
                prod = 128'(t) * 128'(z);
                t = 64'(prod >> 32) / 64'(k);
                if (t == 64'd0)
                    done = 1'b1;
                else if (k % 2 == 1)
                    neg = neg + t;
                else
                    pos = pos + t;
            end
        end
        x = (pos > neg) ? pos - neg : 64'd0;
        if (x > 64'hffff_ffff)
            x = 64'hffff_ffff;
        for (int n = 0; n < 4; n++)
        begin
            x = 64'((128'(x) * 128'(x)) >> 32);
        end
        return E_W'((x + 64'h8000) >> 16);
    endfunction

endpackage

@@ hdl/light_sensor_lux_conversion.sv @@
// Lux conversion for a two-channel chord/step light converter.
// Input stream: one transaction carries both raw channel bytes.
// Output stream: one transaction per input, lux in centilux (signed,
// saturated to +-20000000) plus a status code in tuser (0 ok, 1 invalid
// channel or negative level, 2 converter overflow; lux is 0 unless ok).
// Config channel: index 0 extended range, 1 gain (Q4.12), 2 offset in
// centilux; write only while the pipeline is empty. cfg_ready is always high.
// The pipeline runs from input to output register through the decode,
// ratio divider, exponential table, and rounding and calibration stages.
// Throughput: one transaction per cycle while m_axis_tready is high; every stage
// is registered and the ratio divider resolves one quotient bit per stage.
// Each stage holds its item only while the stage after it is full and
// stalled, so a stalled receiver fills the pipeline before tready drops.
// Reset clears all valid bits and restores the register defaults
// (standard range, gain 1.0, offset 0).
module light_sensor_lux_conversion #(
    parameter int EXP_TABLE_DEPTH = lsl_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // ch0_code, ch1_code
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // lux, zero pad
    output logic [1:0]                          m_axis_tuser,  // status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lsl_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lsl_pkg::*;

    logic                     ext_reg;
    logic [CAL_F_W-1:0]       cal_factor_reg;
    logic signed [CAL_O_W-1:0] cal_offset_reg;

    logic    dec_valid, dec_ready;
    diff_t   dec_data;
    logic    div_valid, div_ready;
    ratio_t  div_data;
    logic    exp_valid, exp_ready;
    expo_t   exp_data;
    status_t res_status;
    logic signed [LUX_W-1:0] res_lux;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg        <= 1'b0;
            cal_factor_reg <= CAL_F_W'(4096);
            cal_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EXT_RANGE:  ext_reg        <= cfg_data[0];
                CFG_CAL_FACTOR: cal_factor_reg <= cfg_data[CAL_F_W-1:0];
                CFG_CAL_OFFSET: cal_offset_reg <= cfg_data[CAL_O_W-1:0];
                default:        ;
            endcase
        end
    end

    lsl_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .ch0_code  (s_axis_tdata[7:0]),
        .ch1_code  (s_axis_tdata[15:8]),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    lsl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    lsl_exp #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp (
        .clk        (clk),
        .rst_n      (rst_n),
        .high_range (ext_reg),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_data    (div_data),
        .out_valid  (exp_valid),
        .out_ready  (exp_ready),
        .out_data   (exp_data)
    );

    lsl_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .cal_factor (cal_factor_reg),
        .cal_offset (cal_offset_reg),
        .in_valid   (exp_valid),
        .in_ready   (exp_ready),
        .in_data    (exp_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .status     (res_status),
        .lux        (res_lux)
    );

    assign m_axis_tdata = {6'b000000, res_lux};
    assign m_axis_tuser = res_status;

endmodule

@@ hdl/lsl_decode.sv @@
module lsl_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [lsl_pkg::CODE_W-1:0] ch0_code,
    input  logic [lsl_pkg::CODE_W-1:0] ch1_code,
    output logic                       out_valid,
    input  logic                       out_ready,
    output lsl_pkg::diff_t             out_data
);
    import lsl_pkg::*;

    logic             v_reg [0:1];
    logic             rdy   [0:2];
    status_t          st_reg,  st_next;
    logic [CNT_W-1:0] c0_reg,  c0_next;
    logic [CNT_W-1:0] c1_reg,  c1_next;
    diff_t            dif_reg, dif_next;

    assign rdy[2] = out_ready;
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[1];
    assign out_data  = dif_reg;

    always_comb
    begin
        st_next = ST_OK;
        if (!ch0_code[7])
            st_next = ST_INVALID;
        else if (ch0_code[6:0] == CODE_OVERFLOW)
            st_next = ST_OVERFLOW;
        else if (!ch1_code[7])
            st_next = ST_INVALID;
        else if (ch1_code[6:0] == CODE_OVERFLOW)
            st_next = ST_OVERFLOW;
        c0_next = count_of(ch0_code[6:0]);
        c1_next = count_of(ch1_code[6:0]);
    end

    always_comb
    begin
        dif_next.status = st_reg;
        dif_next.c1     = c1_reg;
        dif_next.d      = $signed({1'b0, c0_reg}) - $signed({1'b0, c1_reg});
        dif_next.ad     = dif_next.d[D_W-1] ? CNT_W'(-dif_next.d) : CNT_W'(dif_next.d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
            v_reg[1] <= 1'b0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            if (rdy[1])
                v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            st_reg <= st_next;
            c0_reg <= c0_next;
            c1_reg <= c1_next;
        end
        if (rdy[1])
            dif_reg <= dif_next;
    end

endmodule

@@ hdl/lsl_div.sv @@
module lsl_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lsl_pkg::diff_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output lsl_pkg::ratio_t out_data
);
    import lsl_pkg::*;

    logic       v_reg  [0:R_W-1];
    logic       rdy    [0:R_W];
    div_stage_t st_reg [0:R_W-1];

    assign rdy[R_W] = out_ready;
    assign in_ready = rdy[0];
    assign out_valid = v_reg[R_W-1];

    always_comb
    begin
        out_data.status = st_reg[R_W-1].status;
        out_data.d      = st_reg[R_W-1].d;
        out_data.big    = st_reg[R_W-1].big;
        out_data.r      = st_reg[R_W-1].q;
    end

    for (genvar i = 0; i < R_W; i++)
    begin : g_stage
        localparam int B = R_W - 1 - i;
        div_stage_t       cur;
        div_stage_t       st_next;
        logic [CMP_W-1:0] dv;
        logic             v_in;

        if (i == 0)
        begin : g_first
            assign v_in = in_valid;
            always_comb
            begin
                cur.status = in_data.status;
                cur.d      = in_data.d;
                cur.ad     = in_data.ad;
                cur.big    = BIG_W'(in_data.c1) >= (BIG_W'(in_data.ad) << 3);
                cur.rem    = NUM_W'(in_data.c1) << FRAC_W;
                cur.q      = '0;
            end
        end
        else
        begin : g_next
            assign cur  = st_reg[i-1];
            assign v_in = v_reg[i-1];
        end

        assign rdy[i] = !v_reg[i] || rdy[i+1];

        always_comb
        begin
            st_next = cur;
            dv = CMP_W'(cur.ad) << B;
            if (CMP_W'(cur.rem) >= dv)
            begin
                st_next.rem  = NUM_W'(CMP_W'(cur.rem) - dv);
                st_next.q[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (rdy[i])
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i])
                st_reg[i] <= st_next;
        end
    end

endmodule

@@ hdl/lsl_exp.sv @@
module lsl_exp #(
    parameter int DEPTH = lsl_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            high_range,
    input  logic            in_valid,
    output logic            in_ready,
    input  lsl_pkg::ratio_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output lsl_pkg::expo_t  out_data
);
    import lsl_pkg::*;

    localparam int DEP_W = $clog2(DEPTH + 1);
    localparam int PW_W  = R2_W + DEP_W;

    logic [E_W-1:0] exp_rom [0:DEPTH];

    for (genvar g = 0; g <= DEPTH; g++)
    begin : g_rom
        localparam logic [63:0] Y =
            ((64'(EXP_K_MILLI * 64) * 64'(g)) << 32) / (64'd1000 * 64'(DEPTH));
        assign exp_rom[g] = exp_from_y(Y);
    end

    logic v_reg [0:4];
    logic rdy   [0:5];

    status_t                s1_st_reg, s2_st_reg, s3_st_reg, s4_st_reg, s5_st_reg;
    logic signed [DK_W-1:0] s1_dk_reg, s2_dk_reg, s3_dk_reg, s4_dk_reg, s5_dk_reg;
    logic                   s1_big_reg;
    logic [R2_W-1:0]        s1_r2_reg,  s1_r2_next;
    logic signed [DK_W-1:0] s1_dk_next;
    logic                   s2_zero_reg, s2_zero_next, s3_zero_reg, s4_zero_reg;
    logic [DEP_W-1:0]       s2_idx_reg, s2_idx_next;
    logic [FRAC_W-1:0]      s2_f_reg, s3_f_reg;
    logic [E_W-1:0]         s3_t0_reg, s3_diff_reg, s3_diff_next, s4_t0_reg;
    logic [E_W+FRAC_W-1:0]  s4_prod_reg;
    logic [E_W-1:0]         s5_e_reg, s5_e_next;

    logic [2*R_W-1:0]       rr;
    logic [7:0]             km;
    logic signed [D_W+8:0]  dkp;
    logic [PW_W-1:0]        pw;
    logic [DEP_W-1:0]       idx_full;
    logic [E_W-1:0]         t1, t1c;
    logic [E_W+FRAC_W:0]    rnd;

    assign rdy[5] = out_ready;
    for (genvar k = 0; k < 5; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[4];

    always_comb
    begin
        out_data.status = s5_st_reg;
        out_data.dk     = s5_dk_reg;
        out_data.e      = s5_e_reg;
    end

    // square of the ratio, and count difference times gain
    always_comb
    begin
        rr = (2*R_W)'(in_data.r) * (2*R_W)'(in_data.r);
        s1_r2_next = rr[FRAC_W +: R2_W];
        km = high_range ? GAIN_EXT : GAIN_STD;
        dkp = (D_W+9)'(in_data.d) * (D_W+9)'($signed({1'b0, km}));
        s1_dk_next = DK_W'(dkp);
    end

    // table position
    always_comb
    begin
        pw = PW_W'(s1_r2_reg) * PW_W'(DEPTH);
        idx_full = pw[R2_W +: DEP_W];
        s2_zero_next = s1_big_reg || (idx_full >= DEP_W'(DEPTH));
        s2_idx_next = s2_zero_next ? '0 : idx_full;
    end

    always_comb
    begin
        t1  = exp_rom[s2_idx_reg + DEP_W'(1)];
        t1c = (t1 > exp_rom[s2_idx_reg]) ? exp_rom[s2_idx_reg] : t1;
        s3_diff_next = exp_rom[s2_idx_reg] - t1c;
    end

    always_comb
    begin
        rnd = (E_W+FRAC_W+1)'(s4_prod_reg) + (E_W+FRAC_W+1)'(32'h8000);
        s5_e_next = s4_zero_reg ? '0 : s4_t0_reg - E_W'(rnd >> FRAC_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
            if (rdy[4]) v_reg[4] <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_st_reg  <= in_data.status;
            s1_dk_reg  <= s1_dk_next;
            s1_big_reg <= in_data.big;
            s1_r2_reg  <= s1_r2_next;
        end
        if (rdy[1])
        begin
            s2_st_reg   <= s1_st_reg;
            s2_dk_reg   <= s1_dk_reg;
            s2_zero_reg <= s2_zero_next;
            s2_idx_reg  <= s2_idx_next;
            s2_f_reg    <= pw[R2_W-FRAC_W +: FRAC_W];
        end
        if (rdy[2])
        begin
            s3_st_reg   <= s2_st_reg;
            s3_dk_reg   <= s2_dk_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_f_reg    <= s2_f_reg;
            s3_t0_reg   <= exp_rom[s2_idx_reg];
            s3_diff_reg <= s3_diff_next;
        end
        if (rdy[3])
        begin
            s4_st_reg   <= s3_st_reg;
            s4_dk_reg   <= s3_dk_reg;
            s4_zero_reg <= s3_zero_reg;
            s4_t0_reg   <= s3_t0_reg;
            s4_prod_reg <= (E_W+FRAC_W)'(s3_diff_reg) * (E_W+FRAC_W)'(s3_f_reg);
        end
        if (rdy[4])
        begin
            s5_st_reg <= s4_st_reg;
            s5_dk_reg <= s4_dk_reg;
            s5_e_reg  <= s5_e_next;
        end
    end

endmodule

@@ hdl/lsl_round.sv @@
module lsl_round (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [lsl_pkg::CAL_F_W-1:0]        cal_factor,
    input  logic signed [lsl_pkg::CAL_O_W-1:0] cal_offset,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lsl_pkg::expo_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lsl_pkg::status_t                   status,
    output logic signed [lsl_pkg::LUX_W-1:0]   lux
);
    import lsl_pkg::*;

    localparam int V_W   = DK_W + E_W + 1;
    localparam int MAG_W = V_W - 1;
    localparam int M_W   = 21;
    localparam int KP_W  = M_W + 19;
    localparam int L_W   = M_W + 7;
    localparam int G_W   = 25;
    localparam int GP_W  = L_W + CAL_F_W;
    localparam int S_W   = G_W + 2;

    typedef enum logic [1:0] {
        UNIT_1   = 2'd0,
        UNIT_10  = 2'd1,
        UNIT_100 = 2'd2
    } unit_t;

    logic v_reg [0:5];
    logic rdy   [0:6];

    status_t              s1_st_reg, s2_st_reg, s3_st_reg, s4_st_reg, s5_st_reg, s6_st_reg;
    status_t              s2_st_next;
    logic signed [V_W-1:0] s1_v_reg;
    logic                 s2_neg_reg, s3_neg_reg;
    unit_t                s2_unit_reg, s2_unit_next, s3_unit_reg;
    logic [M_W-1:0]       s2_m_reg, s2_m_next, s3_m_reg;
    logic [M_W-1:0]       s3_q_reg, s3_q_next;
    logic [M_W-1:0]       s4_l_reg, s4_l_next;
    logic [G_W-1:0]       s5_g_reg;
    logic signed [LUX_W-1:0] s6_lux_reg, s6_lux_next;

    logic [MAG_W-1:0]     mag;
    logic [MAG_W:0]       msum;
    logic [MAG_W-1:0]     half;
    logic [KP_W-1:0]      kprod;
    logic [L_W-1:0]       l0, rem, unit_val;
    logic [GP_W-1:0]      gp;
    logic signed [S_W-1:0] sum;

    assign rdy[6] = out_ready;
    for (genvar k = 0; k < 6; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[5];
    assign status    = s6_st_reg;
    assign lux       = s6_lux_reg;

    // magnitude, rounding unit, pre-rounded centilux
    always_comb
    begin
        mag = MAG_W'(s1_v_reg[V_W-1] ? -s1_v_reg : s1_v_reg);
        if (mag > MAG_W'(64'd655360000))
        begin
            s2_unit_next = UNIT_100;
            half = MAG_W'(64'd3276800);
        end
        else if (mag > MAG_W'(64'd65536000))
        begin
            s2_unit_next = UNIT_10;
            half = MAG_W'(64'd327680);
        end
        else
        begin
            s2_unit_next = UNIT_1;
            half = MAG_W'(64'd32768);
        end
        msum = (MAG_W+1)'(mag) + (MAG_W+1)'(half);
        s2_m_next = M_W'(msum >> FRAC_W);
        s2_st_next = s1_st_reg;
        if (s1_st_reg == ST_OK && s1_v_reg[V_W-1] && mag >= MAG_W'(64'd32768))
            s2_st_next = ST_INVALID;
    end

    // quotient estimate by reciprocal, low by at most one
    always_comb
    begin
        case (s2_unit_reg)
            UNIT_100: kprod = KP_W'(s2_m_reg) * KP_W'(41943);
            UNIT_10:  kprod = KP_W'(s2_m_reg) * KP_W'(419430);
            default:  kprod = KP_W'(s2_m_reg) << 22;
        endcase
        s3_q_next = M_W'(kprod >> 22);
    end

    always_comb
    begin
        case (s3_unit_reg)
            UNIT_100: unit_val = L_W'(100);
            UNIT_10:  unit_val = L_W'(10);
            default:  unit_val = L_W'(1);
        endcase
        l0  = L_W'(s3_q_reg) * unit_val;
        rem = L_W'(s3_m_reg) - l0;
        s4_l_next = M_W'((rem >= unit_val) ? l0 + unit_val : l0);
        if (s3_neg_reg || s3_st_reg != ST_OK)
            s4_l_next = '0;
    end

    always_comb
    begin
        gp  = GP_W'(s4_l_reg) * GP_W'(cal_factor) + GP_W'(2048);
        sum = $signed({2'b00, s5_g_reg}) + S_W'(cal_offset);
        if (sum > S_W'(LUX_MAX))
            s6_lux_next = LUX_W'(LUX_MAX);
        else if (sum < -S_W'(LUX_MAX))
            s6_lux_next = -LUX_W'(LUX_MAX);
        else
            s6_lux_next = LUX_W'(sum);
        if (s5_st_reg != ST_OK)
            s6_lux_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
            if (rdy[4]) v_reg[4] <= v_reg[3];
            if (rdy[5]) v_reg[5] <= v_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_st_reg <= in_data.status;
            s1_v_reg  <= V_W'(in_data.dk) * V_W'($signed({1'b0, in_data.e}));
        end
        if (rdy[1])
        begin
            s2_st_reg   <= s2_st_next;
            s2_neg_reg  <= s1_v_reg[V_W-1];
            s2_unit_reg <= s2_unit_next;
            s2_m_reg    <= s2_m_next;
        end
        if (rdy[2])
        begin
            s3_st_reg   <= s2_st_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_unit_reg <= s2_unit_reg;
            s3_m_reg    <= s2_m_reg;
            s3_q_reg    <= s3_q_next;
        end
        if (rdy[3])
        begin
            s4_st_reg <= s3_st_reg;
            s4_l_reg  <= s4_l_next;
        end
        if (rdy[4])
        begin
            s5_st_reg <= s4_st_reg;
            s5_g_reg  <= gp[12 +: G_W];
        end
        if (rdy[5])
        begin
            s6_st_reg  <= s5_st_reg;
            s6_lux_reg <= s6_lux_next;
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import lsl_pkg::*;

    localparam int TABLE_D    = 256;
    localparam int DRAIN_WAIT = 40;
    localparam int CYCLE_MAX  = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct {
        status_t            status;
        logic signed [25:0] lux;
    } lux_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lux_result_t pending_lux[$];
    int          mismatches;
    int          cycle_count;
    int          holdoff_cycles;
    bit          no_idle;

    logic        ext_range_q;
    logic [15:0] gain_q;
    logic [20:0] offset_q;
    logic [31:0] exp_lut[0:TABLE_D];

    light_sensor_lux_conversion dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // exp(-0.181*64*i/D) in Q1.16
    function automatic logic [31:0] exp_point(input int i);
        logic [63:0]  y;
        logic [63:0]  z;
        logic [63:0]  acc_pos;
        logic [63:0]  acc_neg;
        logic [63:0]  term;
        logic [63:0]  x;
        logic [127:0] wide;
        if (i == 0)
            return 32'd65536;
        y = ((64'd11584 * 64'(i)) << 32) / (64'd1000 * 64'(TABLE_D));
        z = y >> 4;
        acc_pos = 64'd1 << 32;
        acc_neg = 64'd0;
        term = 64'd1 << 32;
        for (int k = 1; k <= 40; k++)
        begin
            wide = 128'(term) * 128'(z);
            term = 64'(wide >> 32) / 64'(k);
            if (term == 64'd0)
                break;
            if (k % 2 == 1)
                acc_neg += term;
            else
                acc_pos += term;
        end
        x = (acc_pos > acc_neg) ? acc_pos - acc_neg : 64'd0;
        if (x > 64'hffff_ffff)
            x = 64'hffff_ffff;
        for (int n = 0; n < 4; n++)
        begin
            wide = 128'(x) * 128'(x);
            x = 64'(wide >> 32);
        end
        return 32'((x + 64'h8000) >> 16);
    endfunction

    // returns 0 ok, 1 invalid, 2 overflow
    function automatic int byte_to_count(input logic [7:0] b, output longint cnt);
        int chord;
        cnt = 0;
        if (!b[7])
            return 1;
        if (b[6:0] == 7'h7f)
            return 2;
        chord = b[6:4];
        cnt = (33 * ((1 << chord) - 1)) / 2 + (longint'(b[3:0]) << chord);
        return 0;
    endfunction

    function automatic lux_result_t predict_lux(input logic [7:0] b0, input logic [7:0] b1);
        lux_result_t res;
        longint      c0;
        longint      c1;
        longint      d;
        longint      ad;
        longint      r;
        longint      r2;
        longint      p;
        longint      idx;
        longint      frac;
        longint      e;
        longint      v;
        longint      mag;
        longint      unit;
        longint      lux;
        int          st;
        res.status = ST_OK;
        res.lux = '0;
        st = byte_to_count(b0, c0);
        if (st == 0)
            st = byte_to_count(b1, c1);
        if (st == 1)
        begin
            res.status = ST_INVALID;
            return res;
        end
        if (st == 2)
        begin
            res.status = ST_OVERFLOW;
            return res;
        end
        d = c0 - c1;
        if (d == 0)
            e = 65536;
        else
        begin
            ad = (d < 0) ? -d : d;
            r = (c1 << 16) / ad;
            if (r >= (longint'(8) << 16))
                e = 0;
            else
            begin
                r2 = (r * r) >> 16;
                p = (r2 * TABLE_D) >> 6;
                idx = p >> 16;
                frac = p & 16'hffff;
                if (idx >= TABLE_D)
                    e = 0;
                else
                    e = exp_lut[idx] - (((exp_lut[idx] - exp_lut[idx + 1]) * frac
                        + 32768) >> 16);
            end
        end
        v = d * (ext_range_q ? 195 : 39) * e;
        if (v < 0)
        begin
            if (((-v + 32768) >> 16) != 0)
            begin
                res.status = ST_INVALID;
                return res;
            end
            lux = 0;
        end
        else
        begin
            mag = v;
            if (mag > (longint'(10000) << 16))
                unit = 100;
            else if (mag > (longint'(1000) << 16))
                unit = 10;
            else
                unit = 1;
            lux = ((mag + (unit << 15)) / (unit << 16)) * unit;
        end
        lux = (lux * gain_q + 2048) >>> 12;
        lux += longint'($signed(offset_q));
        if (lux > LUX_MAX)
            lux = LUX_MAX;
        if (lux < -LUX_MAX)
            lux = -LUX_MAX;
        res.lux = 26'(lux);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_MAX)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("light_sensor_lux_conversion regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (holdoff_cycles > 0)
        begin
            holdoff_cycles--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle || ($urandom_range(99) >= 9);
    end

    always @(posedge clk)
    begin
        lux_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_lux.size() == 0)
                report_mismatch("unexpected output transaction");
            else
            begin
                exp_r = pending_lux.pop_front();
                if (m_axis_tuser !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                        m_axis_tuser, exp_r.status));
                if (m_axis_tdata[25:0] !== exp_r.lux)
                    report_mismatch($sformatf("lux %0d, expected %0d",
                        $signed(m_axis_tdata[25:0]), exp_r.lux));
            end
        end
    end

    task automatic send_pair(input logic [7:0] b0, input logic [7:0] b1);
        while (!no_idle && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b1, b0};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_lux.push_back(predict_lux(b0, b1));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_lux.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [20:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EXT_RANGE:  ext_range_q = val[0];
            CFG_CAL_FACTOR: gain_q = val[15:0];
            CFG_CAL_OFFSET: offset_q = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_code();
        logic [7:0] b;
        if ($urandom_range(99) < 88)
        begin
            b = {1'b1, 7'($urandom)};
            if (b[6:0] == 7'h7f)
                b[0] = 1'b0;
        end
        else
            b = 8'($urandom);
        return b;
    endfunction

    task automatic send_random(input int n);
        logic [7:0] b0;
        logic [7:0] b1;
        for (int i = 0; i < n; i++)
        begin
            b0 = rand_code();
            case ($urandom_range(3))
                0:       b1 = b0;
                1:       b1 = {b0[7:4], 4'($urandom)};
                2:       b1 = {b0[7], 3'($urandom_range(int'(b0[6:4]))), 4'($urandom)};
                default: b1 = rand_code();
            endcase
            if ($urandom_range(1))
                send_pair(b0, b1);
            else
                send_pair(b1, b0);
        end
    endtask

    task automatic test_directed;
        send_pair(8'h80, 8'h80);
        send_pair(8'hff, 8'h80);
        send_pair(8'h00, 8'hff);
        send_pair(8'h7f, 8'h80);
        send_pair(8'h80, 8'h00);
        send_pair(8'h80, 8'hff);
        send_pair(8'hfe, 8'h80);
        send_pair(8'hfe, 8'hfe);
        send_pair(8'h80, 8'h81);
        send_pair(8'h81, 8'h80);
        send_pair(8'h90, 8'hfe);
        send_pair(8'h91, 8'h90);
        send_pair(8'hfe, 8'hf0);
        send_pair(8'hc5, 8'hb3);
        send_pair(8'ha8, 8'h9c);
        send_pair(8'hbf, 8'h3f);
        send_pair(8'he0, 8'hd7);
        drain();
    endtask

    task automatic test_settings;
        write_reg(CFG_EXT_RANGE, 21'd1);
        write_reg(CFG_CAL_FACTOR, 21'h1fffff);
        write_reg(CFG_CAL_OFFSET, 21'(1000000));
        test_directed();
        send_random(200);
        drain();
        write_reg(CFG_CAL_FACTOR, 21'd0);
        write_reg(CFG_CAL_OFFSET, 21'(-1000000));
        send_random(150);
        drain();
        write_reg(CFG_EXT_RANGE, 21'h1ffffe);
        write_reg(CFG_CAL_FACTOR, 21'd1);
        write_reg(CFG_CAL_OFFSET, 21'h0fffff);
        send_random(150);
        drain();
        write_reg(CFG_CAL_OFFSET, 21'h100000);
        write_reg(CFG_UNUSED_IDX, 21'h1fffff);
        send_random(150);
        drain();
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_EXT_RANGE, 21'($urandom));
            write_reg(CFG_CAL_FACTOR, 21'($urandom));
            write_reg(CFG_CAL_OFFSET, 21'($urandom_range(2000000) - 1000000));
            no_idle = (ph == 2);
            send_random(200);
            drain();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure;
        write_reg(CFG_CAL_FACTOR, 21'd4096);
        holdoff_cycles = 300;
        send_random(120);
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        holdoff_cycles = 0;
        no_idle = 1'b0;
        ext_range_q = 1'b0;
        gain_q = 16'd4096;
        offset_q = '0;
        for (int i = 0; i <= TABLE_D; i++)
            exp_lut[i] = exp_point(i);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_random();
        test_backpressure();
        if (mismatches == 0)
            $display("light_sensor_lux_conversion regression: pass");
        else
            $display("light_sensor_lux_conversion regression: fail");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/lsl_pkg.sv
hdl/lsl_decode.sv
hdl/lsl_div.sv
hdl/lsl_exp.sv
hdl/lsl_round.sv
hdl/light_sensor_lux_conversion.sv
bench/tb.sv
